### design/evad_pkg.sv
// ---------------------------------------------------------------------------
// Energy VAD package
// Shared widths, constants, register indexes and the probability table.
// ---------------------------------------------------------------------------
package evad_pkg;

    localparam int MaxFrameSamples = 1024;
    localparam int LogTableBits    = 8;
    localparam int CountW          = $clog2(MaxFrameSamples + 1);
    localparam int SumW            = 41;
    localparam int XingW           = 10;

    localparam logic [1:0] REG_ADAPT_ENABLE = 2'd0;
    localparam logic [1:0] REG_ADAPT_RATE   = 2'd1;
    localparam logic [1:0] REG_FLOOR        = 2'd2;
    localparam logic [1:0] REG_HANGOVER     = 2'd3;

    localparam logic signed [15:0] DbFloor      = -16'sd24576;
    localparam logic signed [15:0] NoiseReset   = -16'sd12800;
    localparam logic signed [15:0] SignalReset  = -16'sd7680;
    localparam logic signed [15:0] FloorReset   = -16'sd7680;
    localparam logic [15:0]        RateReset    = 16'd655;
    localparam logic [7:0]         HangReset    = 8'd10;
    localparam logic [17:0]        TenLog10Two  = 18'd197283;
    localparam logic [15:0]        ThreshFrac   = 16'd19661;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accum;      // accumulate the accepted sample
        logic log_start;  // load the log unit with the energy sum
        logic log_step;   // one squaring step of the log unit
        logic log_swap;   // keep energy log, load the log unit with the count
        logic conv;       // form the dB value
        logic adapt;      // update the tracked level
        logic thresh;     // update the threshold
        logic decide;     // decide, update counters, load the result register
    } evad_cmd_t;

    typedef struct packed {
        logic log_done;
    } evad_sts_t;

    typedef struct packed {
        logic               speech_flag;
        logic signed [15:0] frame_db;
        logic [7:0]         speech_prob;
        logic [15:0]        speech_run;
        logic [15:0]        silence_run;
        logic [31:0]        frames_total;
        logic [31:0]        speech_total;
    } evad_result_t;

    function automatic logic [7:0] sig_lookup(input logic [5:0] i);
        logic [7:0] v;
        case (i)
            6'd0, 6'd1, 6'd2, 6'd3, 6'd4: v = 8'd1;
            6'd5, 6'd6: v = 8'd2;
            6'd7, 6'd8: v = 8'd3;
            6'd9: v = 8'd4;   6'd10: v = 8'd5;  6'd11: v = 8'd6;
            6'd12: v = 8'd7;  6'd13: v = 8'd8;  6'd14: v = 8'd10;
            6'd15: v = 8'd12; 6'd16: v = 8'd15; 6'd17: v = 8'd18;
            6'd18: v = 8'd21; 6'd19: v = 8'd26; 6'd20: v = 8'd31;
            6'd21: v = 8'd36; 6'd22: v = 8'd43; 6'd23: v = 8'd51;
            6'd24: v = 8'd59; 6'd25: v = 8'd69; 6'd26: v = 8'd79;
            6'd27: v = 8'd91; 6'd28: v = 8'd103; 6'd29: v = 8'd115;
            6'd30: v = 8'd128; 6'd31: v = 8'd141; 6'd32: v = 8'd153;
            6'd33: v = 8'd165; 6'd34: v = 8'd177; 6'd35: v = 8'd187;
            6'd36: v = 8'd197; 6'd37: v = 8'd205; 6'd38: v = 8'd213;
            6'd39: v = 8'd220; 6'd40: v = 8'd225; 6'd41: v = 8'd230;
            6'd42: v = 8'd235; 6'd43: v = 8'd238; 6'd44: v = 8'd241;
            6'd45: v = 8'd244; 6'd46: v = 8'd246; 6'd47: v = 8'd248;
            6'd48: v = 8'd249; 6'd49: v = 8'd250; 6'd50: v = 8'd251;
            6'd51: v = 8'd252;
            6'd52, 6'd53: v = 8'd253;
            6'd54, 6'd55: v = 8'd254;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

### design/evad_if.sv
// ---------------------------------------------------------------------------
// Energy VAD stream interfaces
// Valid/ready channels for sample beats and frame result beats.
// ---------------------------------------------------------------------------
interface evad_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               frame_end;

    modport source (output valid, sample, frame_end, input ready);
    modport sink (input valid, sample, frame_end, output ready);
endinterface

interface evad_out_if;
    logic               valid;
    logic               ready;
    logic               speech_flag;
    logic signed [15:0] frame_db;
    logic [7:0]         speech_prob;
    logic [15:0]        speech_run;
    logic [15:0]        silence_run;
    logic [31:0]        frames_total;
    logic [31:0]        speech_total;

    modport source (output valid, speech_flag, frame_db, speech_prob, speech_run,
                    silence_run, frames_total, speech_total, input ready);
    modport sink (input valid, speech_flag, frame_db, speech_prob, speech_run,
                  silence_run, frames_total, speech_total, output ready);
endinterface

### design/energy_vad_with_hangover.sv
// ---------------------------------------------------------------------------
// Energy voice activity detector with hangover
// Top level: configuration registers, controller, datapath, output register.
// ---------------------------------------------------------------------------
// Usage: sample beats arrive on the in channel, one 16-bit sample each, with
// frame_end set on the last sample of a frame. Ordinary samples are taken one
// per cycle while the controller is idle. The beat with frame_end starts
// the end-of-frame work: a setup step, two 16-step log2 evaluations on one
// squaring unit, then the dB conversion, level update, threshold and
// decision steps, after which the result beat is on the out channel and
// the next sample can be taken in that same cycle. Input is not taken
// during that work. The result sits in an output register; while the
// receiver stalls, plain samples are still taken, but a further frame_end
// beat waits until the held result is taken.
// Configuration writes use cfg_we, cfg_index and cfg_data and take effect
// at once. Reset restores the control and datapath registers to their reset
// values and empties the output register; no clearing pass is needed.
module energy_vad_with_hangover (
    input  logic        clk,
    input  logic        rst_n,
    evad_in_if.sink     in_ch,
    evad_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import evad_pkg::*;

    logic               adapt_enable_reg;
    logic [15:0]        adapt_rate_reg;
    logic signed [15:0] floor_reg;
    logic [7:0]         hang_reg;
    evad_cmd_t          cmd;
    evad_sts_t          sts;
    evad_result_t       res, out_reg;
    logic               out_valid_reg;
    logic               ctrl_ready, out_busy;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adapt_enable_reg <= 1'b1;
            adapt_rate_reg   <= RateReset;
            floor_reg        <= FloorReset;
            hang_reg         <= HangReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ADAPT_ENABLE: adapt_enable_reg <= cfg_data[0];
                REG_ADAPT_RATE:   adapt_rate_reg   <= cfg_data;
                REG_FLOOR:        floor_reg        <= cfg_data;
                REG_HANGOVER:     hang_reg         <= cfg_data[7:0];
                default:          adapt_enable_reg <= adapt_enable_reg;
            endcase
        end
    end

    // Only a frame end needs the output slot to be free.
    assign out_busy     = out_valid_reg && in_ch.frame_end;
    assign in_ch.ready  = ctrl_ready;

    evad_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_frame_end (in_ch.frame_end),
        .in_ready     (ctrl_ready),
        .out_busy     (out_busy),
        .sts          (sts),
        .cmd          (cmd)
    );

    evad_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .sample             (in_ch.sample),
        .adapt_enable       (adapt_enable_reg),
        .adapt_rate         (adapt_rate_reg),
        .floor_threshold_db (floor_reg),
        .hangover_length    (hang_reg),
        .result             (res)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.speech_flag  = out_reg.speech_flag;
    assign out_ch.frame_db     = out_reg.frame_db;
    assign out_ch.speech_prob  = out_reg.speech_prob;
    assign out_ch.speech_run   = out_reg.speech_run;
    assign out_ch.silence_run  = out_reg.silence_run;
    assign out_ch.frames_total = out_reg.frames_total;
    assign out_ch.speech_total = out_reg.speech_total;

endmodule

### design/evad_ctrl.sv
// ---------------------------------------------------------------------------
// Energy VAD controller
// Sequences sample accumulation and the end-of-frame computation.
// ---------------------------------------------------------------------------
module evad_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_frame_end,
    output logic                 in_ready,
    input  logic                 out_busy,
    input  evad_pkg::evad_sts_t  sts,
    output evad_pkg::evad_cmd_t  cmd
);
    import evad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_LOGA, S_LOGB, S_CONV, S_ADAPT, S_THRESH, S_DECIDE
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // A sample is taken only in idle; a frame end also needs a free result slot.
    assign in_ready = (state_reg == S_IDLE) && !out_busy;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accum = accept;
                if (accept && in_frame_end)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                // The last sample is in the accumulators by now.
                cmd.log_start = 1'b1;
                state_next    = S_LOGA;
            end
            S_LOGA:
            begin
                if (sts.log_done)
                begin
                    cmd.log_swap = 1'b1;
                    state_next   = S_LOGB;
                end
                else
                begin
                    cmd.log_step = 1'b1;
                end
            end
            S_LOGB:
            begin
                if (sts.log_done)
                begin
                    state_next = S_CONV;
                end
                else
                begin
                    cmd.log_step = 1'b1;
                end
            end
            S_CONV:
            begin
                cmd.conv   = 1'b1;
                state_next = S_ADAPT;
            end
            S_ADAPT:
            begin
                cmd.adapt  = 1'b1;
                state_next = S_THRESH;
            end
            S_THRESH:
            begin
                cmd.thresh = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/evad_dp.sv
// ---------------------------------------------------------------------------
// Energy VAD datapath
// Frame accumulators, iterative log2 unit, level tracking and decision.
// ---------------------------------------------------------------------------
module evad_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  evad_pkg::evad_cmd_t    cmd,
    output evad_pkg::evad_sts_t    sts,
    input  logic signed [15:0]     sample,
    input  logic                   adapt_enable,
    input  logic [15:0]            adapt_rate,
    input  logic signed [15:0]     floor_threshold_db,
    input  logic [7:0]             hangover_length,
    output evad_pkg::evad_result_t result
);
    import evad_pkg::*;

    localparam int LogStepW = 5;
    localparam int ExpW     = 6;

    // Frame accumulators.
    logic [SumW-1:0]   esum_reg;
    logic [CountW-1:0] count_reg;
    logic [XingW-1:0]  xing_reg;
    logic              prevneg_reg;
    logic [31:0]       sq;
    logic              neg;

    assign neg = sample[15];
    assign sq  = 32'(sample) * 32'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esum_reg    <= '0;
            count_reg   <= '0;
            xing_reg    <= '0;
            prevneg_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            esum_reg    <= '0;
            count_reg   <= '0;
            xing_reg    <= '0;
            prevneg_reg <= 1'b0;
        end
        else if (cmd.accum && (count_reg < CountW'(MaxFrameSamples)))
        begin
            esum_reg  <= esum_reg + SumW'(sq);
            count_reg <= count_reg + 1'b1;
            prevneg_reg <= neg;
            if ((count_reg != '0) && (neg != prevneg_reg))
            begin
                xing_reg <= xing_reg + 1'b1;
            end
        end
    end

    // Log2 unit: leading one, mantissa, 16 squaring steps one per cycle.
    logic [SumW-1:0]     lin;
    logic [ExpW-1:0]     lead;
    logic [LogTableBits-1:0] idx;
    logic [31:0]         y_reg;
    logic [15:0]         f_reg;
    logic [ExpW-1:0]     e_reg;
    logic [LogStepW-1:0] step_reg;
    logic [63:0]         ysq;
    logic [33:0]         ynew;
    logic [ExpW+15:0]    loga_reg;
    logic                log_zero_reg;

    assign lin = cmd.log_swap ? SumW'(count_reg) : esum_reg;

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < SumW; i++)
        begin
            if (lin[i])
            begin
                lead = ExpW'(i);
            end
        end
    end

    always_comb
    begin
        logic [SumW+LogTableBits-1:0] sh;
        sh  = {lin, {LogTableBits{1'b0}}} >> lead;
        idx = sh[LogTableBits-1:0];
    end

    assign ysq  = {32'd0, y_reg} * {32'd0, y_reg};
    assign ynew = 34'(ysq >> 30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            y_reg        <= '0;
            f_reg        <= '0;
            e_reg        <= '0;
            loga_reg     <= '0;
            log_zero_reg <= 1'b0;
        end
        else if (cmd.log_start || cmd.log_swap)
        begin
            step_reg <= '0;
            e_reg    <= lead;
            f_reg    <= '0;
            y_reg    <= 32'({1'b1, idx}) << (30 - LogTableBits);
            if (cmd.log_swap)
            begin
                loga_reg <= {e_reg, f_reg};
            end
            else
            begin
                log_zero_reg <= (esum_reg == '0) || (count_reg == '0);
            end
        end
        else if (cmd.log_step)
        begin
            step_reg <= step_reg + 1'b1;
            if (ynew[31])
            begin
                y_reg <= 32'(ynew >> 1);
                f_reg <= {f_reg[14:0], 1'b1};
            end
            else
            begin
                y_reg <= ynew[31:0];
                f_reg <= {f_reg[14:0], 1'b0};
            end
        end
    end

    assign sts.log_done = (step_reg == LogStepW'(16));

    // dB conversion with rounding and clamping.
    logic signed [ExpW+17:0] d;
    logic signed [47:0]      prod;
    logic signed [47:0]      mag;
    logic signed [47:0]      db;
    logic signed [15:0]      e_db_reg;

    assign d    = $signed({2'b00, loga_reg}) - $signed({2'b00, e_reg, f_reg})
                  - $signed((ExpW+18)'(30 * 65536));
    assign prod = 48'(d) * $signed({30'd0, TenLog10Two});
    assign mag  = prod[47] ? -prod : prod;

    always_comb
    begin
        logic signed [47:0] r;
        r  = (mag + 48'sd8388608) >>> 24;
        db = prod[47] ? -r : r;
    end

    // Rounded weighted step from one level toward another.
    function automatic logic signed [15:0] toward(
        input logic signed [15:0] from,
        input logic signed [15:0] to,
        input logic [15:0]        w
    );
        logic signed [17:0] diff;
        logic signed [34:0] p;
        logic [34:0]        m;
        logic [34:0]        r;
        logic signed [18:0] res;
        diff = 18'(to) - 18'(from);
        p    = 35'(diff) * $signed({19'd0, w});
        m    = p[34] ? 35'(-p) : 35'(p);
        r    = (m + 35'd32768) >> 16;
        res  = p[34] ? -$signed(19'(r)) : $signed(19'(r));
        return 16'(19'(from) + res);
    endfunction

    // Levels, threshold, and the per-frame decision.
    logic signed [15:0] noise_reg, signal_reg, thr_reg, t_new;
    logic               prev_speech_reg;
    logic [7:0]         hold_reg;
    logic [15:0]        srun_reg, qrun_reg;
    logic [31:0]        ftot_reg, stot_reg;
    logic               raw, spk, zcr_hi;
    logic signed [16:0] snr;
    logic signed [9:0]  kk;
    logic [5:0]         kidx;

    assign t_new = toward(noise_reg, signal_reg, ThreshFrac);
    assign zcr_hi = (count_reg >= CountW'(2)) &&
                    ((15'(xing_reg) * 15'd10) > (15'(count_reg - 1'b1) * 15'd7));
    assign raw = (e_db_reg > thr_reg) && !zcr_hi;
    assign spk = raw || (hold_reg != '0);
    assign snr = 17'(e_db_reg) - 17'(noise_reg);

    always_comb
    begin
        logic signed [16:0] rs;
        rs = snr[16] ? -((-snr + 17'sd128) >>> 8) : ((snr + 17'sd128) >>> 8);
        kk = 10'(rs) - 10'sd10;
        if (kk < -10'sd30)
        begin
            kk = -10'sd30;
        end
        else if (kk > 10'sd30)
        begin
            kk = 10'sd30;
        end
        kidx = 6'(kk + 10'sd30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_db_reg        <= DbFloor;
            noise_reg       <= NoiseReset;
            signal_reg      <= SignalReset;
            thr_reg         <= FloorReset;
            prev_speech_reg <= 1'b0;
            hold_reg        <= '0;
            srun_reg        <= '0;
            qrun_reg        <= '0;
            ftot_reg        <= '0;
            stot_reg        <= '0;
        end
        else
        begin
            if (cmd.conv)
            begin
                if (log_zero_reg || (db < -48'sd24576))
                begin
                    e_db_reg <= DbFloor;
                end
                else if (db > 48'sd0)
                begin
                    e_db_reg <= '0;
                end
                else
                begin
                    e_db_reg <= 16'(db);
                end
            end
            if (cmd.adapt && adapt_enable)
            begin
                if (prev_speech_reg)
                begin
                    signal_reg <= toward(signal_reg, e_db_reg, adapt_rate);
                end
                else
                begin
                    noise_reg <= toward(noise_reg, e_db_reg, adapt_rate);
                end
            end
            if (cmd.thresh && adapt_enable)
            begin
                thr_reg <= (t_new < floor_threshold_db) ? floor_threshold_db : t_new;
            end
            if (cmd.decide)
            begin
                if (raw)
                begin
                    hold_reg <= hangover_length;
                end
                else if (hold_reg != '0)
                begin
                    hold_reg <= hold_reg - 1'b1;
                end
                prev_speech_reg <= spk;
                if (spk)
                begin
                    if (srun_reg != 16'hFFFF) srun_reg <= srun_reg + 1'b1;
                    qrun_reg <= '0;
                    if (stot_reg != 32'hFFFFFFFF) stot_reg <= stot_reg + 1'b1;
                end
                else
                begin
                    if (qrun_reg != 16'hFFFF) qrun_reg <= qrun_reg + 1'b1;
                    srun_reg <= '0;
                end
                if (ftot_reg != 32'hFFFFFFFF) ftot_reg <= ftot_reg + 1'b1;
            end
        end
    end

    // Result payload, captured by the output stage on decide.
    always_comb
    begin
        result.speech_flag  = spk;
        result.frame_db     = e_db_reg;
        result.speech_prob  = sig_lookup(kidx);
        result.speech_run   = (spk ? ((srun_reg != 16'hFFFF) ? srun_reg + 1'b1 : srun_reg)
                               : '0);
        result.silence_run  = (!spk ? ((qrun_reg != 16'hFFFF) ? qrun_reg + 1'b1 : qrun_reg)
                               : '0);
        result.frames_total = (ftot_reg != 32'hFFFFFFFF) ? ftot_reg + 1'b1 : ftot_reg;
        result.speech_total = (spk && (stot_reg != 32'hFFFFFFFF)) ? stot_reg + 1'b1
                              : stot_reg;
    end

endmodule

### design/evad_checker.sv
// ---------------------------------------------------------------------------
// Energy VAD port checker
// Port-level properties of the detector, bound to the top level.
// ---------------------------------------------------------------------------
module evad_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               in_frame_end,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] frame_db,
    input logic               speech_flag,
    input logic [15:0]        speech_run,
    input logic [15:0]        silence_run
);
    // A result is held until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_db))
        else $error("result dropped while stalled");

    // A frame end beat is never taken while a result is waiting.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_frame_end |-> !out_valid || out_ready)
        else $error("frame end taken over a pending result");

    // Exactly one run counter is nonzero, matching the decision.
    a_runs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (speech_flag ? (speech_run != 0 && silence_run == 0)
                                   : (silence_run != 0 && speech_run == 0)))
        else $error("run counters inconsistent with decision");

    // Energy stays within the dB range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_db <= 0 && frame_db >= -16'sd24576)
        else $error("energy out of range");
endmodule

bind energy_vad_with_hangover evad_checker u_evad_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_frame_end (in_ch.frame_end),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .frame_db     (out_ch.frame_db),
    .speech_flag  (out_ch.speech_flag),
    .speech_run   (out_ch.speech_run),
    .silence_run  (out_ch.silence_run)
);

### tb/energy_vad_with_hangover_tb.sv
// ---------------------------------------------------------------------------
// Energy VAD testbench
// Drives frames of audio samples through the detector and checks every
// frame result beat against a cycle-free prediction of the frame energy,
// the adaptive threshold, the decision with hangover and the counters.
// Both sides idle at random, and the register settings change between phases.
// ---------------------------------------------------------------------------
module energy_vad_with_hangover_tb;
    import evad_pkg::*;

    typedef struct {
        logic signed [15:0] sample;
        logic               frame_end;
    } sample_beat_t;

    localparam int CycleLimit = 1500000;
    localparam int DrainWait  = 80;

    // Sigmoid probability table, indexed by clamped SNR step plus 30.
    localparam byte unsigned ProbTable [0:60] = '{
        1, 1, 1, 1, 1, 2, 2, 3, 3, 4,
        5, 6, 7, 8, 10, 12, 15, 18, 21, 26,
        31, 36, 43, 51, 59, 69, 79, 91, 103, 115,
        128,
        141, 153, 165, 177, 187, 197, 205, 213, 220, 225,
        230, 235, 238, 241, 244, 246, 248, 249, 250, 251,
        252, 253, 253, 254, 254, 255, 255, 255, 255, 255
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    evad_in_if  in_if ();
    evad_out_if out_if ();

    energy_vad_with_hangover dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Pending sample beats and expected frame results.
    sample_beat_t  sample_q[$];
    evad_result_t  frame_result_q[$];
    int            mismatches;
    int            cycle_count;

    // Shadow registers and detector state.
    bit              m_adapt_en;
    int unsigned     m_rate;
    int              m_floor;
    int unsigned     m_hang;
    longint unsigned m_sum;
    int unsigned     m_count;
    int unsigned     m_xings;
    bit              m_prev_neg;
    int              m_noise;
    int              m_signal;
    int              m_thresh;
    bit              m_prev_speech;
    int unsigned     m_hold;
    int unsigned     m_speech_run;
    int unsigned     m_silence_run;
    int unsigned     m_frames;
    int unsigned     m_speech_frames;

    // Handshake bookkeeping between the clocked processes.
    bit tx_idle_on;
    bit rx_idle_on;
    bit beat_taken;
    bit result_taken;
    int tx_gap;
    int rx_gap;
    int stall_len;
    int stall_req;
    int stall_done;

    always #1 clk = ~clk;

    // Round to nearest, ties away from zero, after an arithmetic shift.
    function automatic longint round_sh(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    // Base-2 logarithm in Q.16 with an 8-bit mantissa cut.
    function automatic longint log2_fixed(longint unsigned x);
        int unsigned     e;
        longint unsigned t;
        longint unsigned idx;
        longint unsigned y;
        longint unsigned f;
        e = 0;
        t = x;
        f = 0;
        while (t > 1)
        begin
            t = t >> 1;
            e++;
        end
        if (e >= LogTableBits)
            idx = (x >> (e - LogTableBits)) & ((64'd1 << LogTableBits) - 1);
        else
            idx = (x << (LogTableBits - e)) & ((64'd1 << LogTableBits) - 1);
        y = ((64'd1 << LogTableBits) | idx) << (30 - LogTableBits);
        for (int i = 0; i < 16; i++)
        begin
            y = (y * y) >> 30;
            f = f << 1;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                f = f | 1;
            end
        end
        return longint'(e) * 65536 + longint'(f);
    endfunction

    function automatic int move_toward(int from_lvl, int to_lvl, int unsigned w);
        return from_lvl + int'(round_sh(longint'(to_lvl - from_lvl) * longint'(w), 16));
    endfunction

    // Advance the detector by one accepted sample beat.
    task automatic predict_beat(logic signed [15:0] smp, logic fe);
        bit           neg;
        bit           speech;
        int           e_db;
        longint       d;
        longint       k;
        evad_result_t r;
        neg = smp < 0;
        if (m_count < MaxFrameSamples)
        begin
            m_sum += longint'(smp) * longint'(smp);
            if (m_count > 0 && neg != m_prev_neg)
                m_xings++;
            m_prev_neg = neg;
            m_count++;
        end
        if (!fe)
            return;

        // Mean frame energy in dB.
        if (m_sum == 0 || m_count == 0)
            e_db = int'(DbFloor);
        else
        begin
            d = log2_fixed(m_sum) - log2_fixed(m_count) - longint'(30) * 65536;
            d = round_sh(d * 197283, 24);
            if (d < DbFloor)
                d = DbFloor;
            if (d > 0)
                d = 0;
            e_db = int'(d);
        end

        // Level tracking and threshold.
        if (m_adapt_en)
        begin
            if (!m_prev_speech)
                m_noise = move_toward(m_noise, e_db, m_rate);
            else
                m_signal = move_toward(m_signal, e_db, m_rate);
            m_thresh = move_toward(m_noise, m_signal, 19661);
            if (m_thresh < m_floor)
                m_thresh = m_floor;
        end
        speech = e_db > m_thresh;
        if (m_count >= 2 && longint'(m_xings) * 10 > longint'(m_count - 1) * 7)
            speech = 0;

        k = round_sh(longint'(e_db - m_noise), 8) - 10;
        if (k < -30)
            k = -30;
        if (k > 30)
            k = 30;

        // Hangover and counters.
        if (speech)
            m_hold = m_hang;
        else if (m_hold > 0)
        begin
            m_hold--;
            speech = 1;
        end
        if (speech)
        begin
            if (m_speech_run < 32'hFFFF)
                m_speech_run++;
            m_silence_run = 0;
            if (m_speech_frames != 32'hFFFF_FFFF)
                m_speech_frames++;
        end
        else
        begin
            if (m_silence_run < 32'hFFFF)
                m_silence_run++;
            m_speech_run = 0;
        end
        if (m_frames != 32'hFFFF_FFFF)
            m_frames++;
        m_prev_speech = speech;

        r.speech_flag  = speech;
        r.frame_db     = 16'(e_db);
        r.speech_prob  = ProbTable[k + 30];
        r.speech_run   = 16'(m_speech_run);
        r.silence_run  = 16'(m_silence_run);
        r.frames_total = m_frames;
        r.speech_total = m_speech_frames;
        frame_result_q.push_back(r);

        m_sum      = 0;
        m_count    = 0;
        m_xings    = 0;
        m_prev_neg = 0;
    endtask

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch in frame result field %s: got %0d, expected %0d",
                 field, got, want);
        mismatches++;
    endtask

    // Sample beat driver.
    always @(negedge clk)
    begin
        sample_beat_t b;
        if (rst_n && !(in_if.valid && !beat_taken))
        begin
            beat_taken = 0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_if.valid <= 1'b0;
            end
            else if (sample_q.size() > 0)
            begin
                b = sample_q.pop_front();
                in_if.sample    <= b.sample;
                in_if.frame_end <= b.frame_end;
                in_if.valid     <= 1'b1;
                tx_gap = tx_idle_on ? $urandom_range(0, 13) : 0;
            end
            else
                in_if.valid <= 1'b0;
        end
    end

    // Acceptance of sample beats.
    always @(posedge clk)
    begin
        if (rst_n && in_if.valid && in_if.ready)
        begin
            beat_taken = 1;
            predict_beat(in_if.sample, in_if.frame_end);
        end
    end

    // Result receiver: random stalls and requested long hold-offs.
    always @(negedge clk)
    begin
        if (result_taken)
        begin
            result_taken = 0;
            rx_gap = rx_idle_on ? $urandom_range(0, 13) : 0;
        end
        if (stall_len > 0)
        begin
            stall_len--;
            out_if.ready <= 1'b0;
        end
        else if (stall_done < stall_req)
        begin
            stall_done++;
            stall_len = 600;
            out_if.ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_if.ready <= 1'b0;
        end
        else
            out_if.ready <= 1'b1;
    end

    // Frame result monitor.
    always @(posedge clk)
    begin
        evad_result_t w;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            result_taken = 1;
            if (frame_result_q.size() == 0)
            begin
                report_mismatch("pending frames", 0, 1);
            end
            else
            begin
                w = frame_result_q.pop_front();
                if (out_if.speech_flag !== w.speech_flag)
                    report_mismatch("speech_flag", out_if.speech_flag, w.speech_flag);
                if (out_if.frame_db !== w.frame_db)
                    report_mismatch("frame_db", out_if.frame_db, w.frame_db);
                if (out_if.speech_prob !== w.speech_prob)
                    report_mismatch("speech_prob", out_if.speech_prob, w.speech_prob);
                if (out_if.speech_run !== w.speech_run)
                    report_mismatch("speech_run", out_if.speech_run, w.speech_run);
                if (out_if.silence_run !== w.silence_run)
                    report_mismatch("silence_run", out_if.silence_run, w.silence_run);
                if (out_if.frames_total !== w.frames_total)
                    report_mismatch("frames_total", out_if.frames_total, w.frames_total);
                if (out_if.speech_total !== w.speech_total)
                    report_mismatch("speech_total", out_if.speech_total, w.speech_total);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("energy_vad_with_hangover_tb failed");
            $finish;
        end
    end

    // Register write, mirrored in the shadow registers.
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ADAPT_ENABLE: m_adapt_en = val[0];
            REG_ADAPT_RATE:   m_rate = val;
            REG_FLOOR:        m_floor = int'($signed(val));
            REG_HANGOVER:     m_hang = val[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all(bit en, logic [15:0] rate, int flr, logic [7:0] hang);
        write_reg(REG_ADAPT_ENABLE, {15'd0, en});
        write_reg(REG_ADAPT_RATE, rate);
        write_reg(REG_FLOOR, 16'(flr));
        write_reg(REG_HANGOVER, {8'd0, hang});
    endtask

    // Wait until every beat is sent and every frame result has come back.
    task automatic wait_drained();
        while (sample_q.size() > 0 || in_if.valid || frame_result_q.size() > 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    // Queue one frame; style 0 quiet, 1 loud, 2 alternating, 3 full range.
    task automatic push_frame(int len, int style);
        sample_beat_t b;
        int           amp;
        amp = (style == 0) ? $urandom_range(0, 60) : $urandom_range(3000, 32767);
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0, 1:    b.sample = 16'($signed($urandom_range(0, 2 * amp)) - amp);
                2:       b.sample = (i % 2) ? 16'(amp) : -16'(amp);
                default: b.sample = 16'($urandom);
            endcase
            b.frame_end = (i == len - 1);
            sample_q.push_back(b);
        end
    endtask

    // Random frames with content shaped into speech and silence bursts.
    task automatic random_phase(int beats);
        int n;
        int style;
        int burst;
        int len;
        n = 0;
        burst = 0;
        style = 0;
        while (n < beats)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 8);
                style = $urandom_range(0, 9);
                style = (style < 4) ? 0 : (style < 8) ? 1 : (style == 8) ? 2 : 3;
            end
            burst--;
            len = $urandom_range(1, 30);
            push_frame(len, style);
            n += len;
        end
    endtask

    initial
    begin
        sample_beat_t b;
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_ADAPT_ENABLE;
        cfg_data = 0;
        in_if.valid = 0;
        in_if.sample = 0;
        in_if.frame_end = 0;
        out_if.ready = 0;
        mismatches = 0;
        cycle_count = 0;
        tx_idle_on = 1;
        rx_idle_on = 1;
        beat_taken = 0;
        result_taken = 0;
        tx_gap = 0;
        rx_gap = 0;
        stall_len = 0;
        stall_req = 0;
        stall_done = 0;

        // Reset state of the detector.
        m_adapt_en = 1;
        m_rate = RateReset;
        m_floor = int'(FloorReset);
        m_hang = HangReset;
        m_sum = 0;
        m_count = 0;
        m_xings = 0;
        m_prev_neg = 0;
        m_noise = int'(NoiseReset);
        m_signal = int'(SignalReset);
        m_thresh = int'(FloorReset);
        m_prev_speech = 0;
        m_hold = 0;
        m_speech_run = 0;
        m_silence_run = 0;
        m_frames = 0;
        m_speech_frames = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: silent frame, single extreme samples, alternating signs,
        // full scale, and a frame longer than the accumulator takes.
        push_frame(4, 0);
        b.sample = 0;
        b.frame_end = 1;
        sample_q.push_back(b);
        b.sample = -16'sd32768;
        sample_q.push_back(b);
        b.sample = 16'sd32767;
        sample_q.push_back(b);
        for (int i = 0; i < 6; i++)
        begin
            b.sample = (i % 2) ? 16'sd32767 : -16'sd32768;
            b.frame_end = (i == 5);
            sample_q.push_back(b);
        end
        push_frame(5, 1);
        push_frame(3, 3);
        push_frame(1030, 1);
        wait_drained();

        // Phase with default registers and a long receiver hold-off.
        stall_req++;
        random_phase(140);
        wait_drained();

        // Adaptation off, fastest rate, highest floor, no hangover.
        tx_idle_on = 0;
        write_all(1'b0, 16'hFFFF, 0, 8'd0);
        random_phase(100);
        wait_drained();

        // Adaptation on, frozen rate, lowest floor, longest hangover.
        tx_idle_on = 1;
        rx_idle_on = 0;
        write_all(1'b1, 16'h0000, -24576, 8'd255);
        random_phase(100);
        wait_drained();

        // Fast tracking with extreme floor, then random settings.
        rx_idle_on = 1;
        write_all(1'b1, 16'hFFFF, -24576, 8'd1);
        random_phase(80);
        wait_drained();
        for (int p = 0; p < 3; p++)
        begin
            write_all(1'($urandom), 16'($urandom), -int'($urandom_range(0, 24576)),
                      8'($urandom));
            random_phase(80);
            wait_drained();
        end

        if (mismatches == 0)
            $display("energy_vad_with_hangover_tb passed");
        else
            $display("energy_vad_with_hangover_tb failed");
        $finish;
    end

endmodule

### filelist.f
design/evad_pkg.sv
design/evad_if.sv
design/evad_ctrl.sv
design/evad_dp.sv
design/energy_vad_with_hangover.sv
design/evad_checker.sv
tb/energy_vad_with_hangover_tb.sv
